[hdl/lpp_pkg.sv]
// lpp_pkg: shared constants, types and lookup functions for the line position pid block
// used by lpp_div and line_position_pid; no dependencies
package lpp_pkg;

    localparam int HISTORY_DEPTH = 10;
    localparam int FRAC_BITS     = 4;

    localparam int SENS_W = 8;
    localparam int ERR_W  = 10;
    localparam int CTL_W  = 21;
    localparam int GAIN_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam int ERR_MIN = -(1 << (ERR_W - 1));
    localparam int ERR_MAX = (1 << (ERR_W - 1)) - 1;

    // running sum of the window
    localparam int HSUM_W = ERR_W + $clog2(HISTORY_DEPTH);
    // second multiplier operand carries error, error difference or window sum
    localparam int MB_W   = (HSUM_W > ERR_W + 1) ? HSUM_W : ERR_W + 1;
    localparam int PROD_W = GAIN_W + MB_W;
    localparam int ACC_W  = PROD_W + 2;

    // weighted sum of set bits: -13..13, times 5, times 2^FRAC_BITS
    localparam int WSUM_W = 5;
    localparam int NUM_W  = 8 + FRAC_BITS;
    localparam int DIVD_W = NUM_W - 1;
    localparam int DIVS_W = 4;
    localparam int DCNT_W = $clog2(DIVD_W + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP  = 2'd0,
        REG_GAIN_INTEG = 2'd1,
        REG_GAIN_DERIV = 2'd2
    } t_cfg_reg;

    typedef logic signed [ERR_W-1:0] t_err;

    typedef struct packed {
        logic              hit;
        logic signed [7:0] half;   // error in halves of a sensor step
    } t_lookup;

    function automatic t_lookup pattern_lookup(input logic [SENS_W-1:0] bits);
        t_lookup r;
        r.hit  = 1'b1;
        r.half = 8'sd0;
        case (bits)
            8'h18, 8'h3C:        r.half = 8'sd0;
            8'h08, 8'h0C, 8'h1E: r.half = 8'sd15;
            8'h20, 8'h30, 8'h78: r.half = -8'sd15;
            8'h02, 8'h06, 8'h0F: r.half = 8'sd25;
            8'h40, 8'h60, 8'hF0: r.half = -8'sd25;
            8'h01, 8'h03:        r.half = 8'sd60;
            8'h80, 8'hC0:        r.half = -8'sd60;
            8'h1C:               r.half = 8'sd8;
            8'h38:               r.half = -8'sd8;
            8'h0E:               r.half = 8'sd20;
            8'h70:               r.half = -8'sd20;
            8'h07:               r.half = 8'sd32;
            8'hE0:               r.half = -8'sd32;
            default:             r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // sensor weight, index 0 is the leftmost sensor
    function automatic logic signed [WSUM_W-1:0] sensor_weight(input int idx);
        logic signed [WSUM_W-1:0] w;
        case (idx)
            0:       w = -5'sd6;
            1:       w = -5'sd4;
            2:       w = -5'sd2;
            3:       w = -5'sd1;
            4:       w = 5'sd1;
            5:       w = 5'sd2;
            6:       w = 5'sd4;
            7:       w = 5'sd6;
            default: w = 5'sd0;
        endcase
        return w;
    endfunction

    function automatic t_err sat_err(input logic signed [31:0] v);
        logic signed [31:0] c;
        c = v;
        if (v < ERR_MIN) c = ERR_MIN;
        if (v > ERR_MAX) c = ERR_MAX;
        return c[ERR_W-1:0];
    endfunction

endpackage

[hdl/lpp_div.sv]
// lpp_div: unsigned restoring divider, one quotient bit per cycle
// depends on lpp_pkg for operand widths
module lpp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lpp_pkg::DIVD_W-1:0] i_dividend,
    input  logic [lpp_pkg::DIVS_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [lpp_pkg::DIVD_W-1:0] o_quotient
);
    import lpp_pkg::*;

    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIVS_W-1:0] trial;
    logic              ge;

    // remainder stays below the divisor, so the top bit shifts out as zero
    assign trial = {r_rem[DIVS_W-2:0], r_quo[DIVD_W-1]};
    assign ge    = (trial >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], ge};
            r_rem <= ge ? (trial - r_dvs) : trial;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/line_position_pid.sv]
// line_position_pid: sensor pattern to position error and pid correction, top level
// depends on lpp_pkg and lpp_div
//
// One item is taken at a time. A pattern found in the fixed table, or the all-zero
// pattern, goes from lookup to the multiply steps; any other pattern first goes through
// the serial divider (one quotient bit per cycle, 11 bits). The three gain products
// share one 16-bit signed multiplier, one product per cycle, with the sum registered
// behind it. The result sits in an output register, so the next item can be taken
// while it waits. Gains are to be written on the cfg channel only while the block is
// idle (not enforced by the block itself); a write to an index above 2 is ignored.
module line_position_pid (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lpp_pkg::SENS_W-1:0]        i_sensor_bits,
    input  logic                              i_record_history,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [lpp_pkg::ERR_W-1:0]  o_position_error,
    output logic signed [lpp_pkg::CTL_W-1:0]  o_control_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lpp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lpp_pkg::GAIN_W-1:0]        i_cfg_data
);
    import lpp_pkg::*;

    localparam int SH_W = ACC_W - 8;
    localparam logic signed [SH_W-1:0] CTL_LO = -(SH_W'(1) <<< (CTL_W - 1));
    localparam logic signed [SH_W-1:0] CTL_HI = (SH_W'(1) <<< (CTL_W - 1)) - SH_W'(1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOOK = 5'b00010,
        S_DIV  = 5'b00100,
        S_MUL  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state                    r_state;
    logic signed [GAIN_W-1:0]  r_gain_p, r_gain_i, r_gain_d;
    logic [SENS_W-1:0]         r_bits;
    logic                      r_rec;
    t_err                      r_err;
    t_err                      r_last;
    t_err                      r_hist [HISTORY_DEPTH];
    logic signed [HSUM_W-1:0]  r_hsum;
    logic                      r_neg;
    logic [1:0]                r_step;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    t_err                      r_out_err;
    logic signed [CTL_W-1:0]   r_out_ctl;

    t_lookup                   lk;
    logic signed [WSUM_W-1:0]  wsum;
    logic [DIVS_W-1:0]         cnt;
    logic signed [NUM_W-1:0]   num;
    logic [DIVD_W-1:0]         num_mag;
    logic                      div_done;
    logic [DIVD_W-1:0]         div_quo;
    logic signed [NUM_W-1:0]   quo_s;
    logic signed [GAIN_W-1:0]  mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [ERR_W:0]     err_diff;
    logic signed [SH_W-1:0]    acc_sh;
    logic signed [CTL_W-1:0]   ctl_sat;
    logic                      out_free;

    // pattern decode and weighted average numerator
    always_comb begin
        lk   = pattern_lookup(r_bits);
        wsum = '0;
        cnt  = '0;
        for (int k = 0; k < SENS_W; k++) begin
            if (r_bits[SENS_W-1-k]) begin
                wsum = wsum + sensor_weight(k);
                cnt  = cnt + 1'b1;
            end
        end
        num     = ((NUM_W'(wsum) <<< 2) + NUM_W'(wsum)) <<< FRAC_BITS;
        num_mag = num[NUM_W-1] ? DIVD_W'(-num) : DIVD_W'(num);
    end

    lpp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOOK),
        .i_dividend (num_mag),
        .i_divisor  (cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign quo_s = r_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    // shared multiplier operand select
    assign err_diff = (ERR_W+1)'(r_err) - (ERR_W+1)'(r_last);
    always_comb begin
        case (r_step)
            2'd0:    begin mul_a = r_gain_p; mul_b = MB_W'(r_err);    end
            2'd1:    begin mul_a = r_gain_i; mul_b = MB_W'(r_hsum);   end
            2'd2:    begin mul_a = r_gain_d; mul_b = MB_W'(err_diff); end
            default: begin mul_a = '0;       mul_b = '0;              end
        endcase
    end

    // floor shift by 8 then clamp
    assign acc_sh = r_acc[ACC_W-1:8];
    always_comb begin
        if (acc_sh < CTL_LO)
            ctl_sat = CTL_LO[CTL_W-1:0];
        else if (acc_sh > CTL_HI)
            ctl_sat = CTL_HI[CTL_W-1:0];
        else
            ctl_sat = acc_sh[CTL_W-1:0];
    end

    assign out_free = !r_out_valid || i_out_ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_last      <= '0;
            r_hsum      <= '0;
            for (int k = 0; k < HISTORY_DEPTH; k++)
                r_hist[k] <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GAIN_PROP:  r_gain_p <= i_cfg_data;
                    REG_GAIN_INTEG: r_gain_i <= i_cfg_data;
                    REG_GAIN_DERIV: r_gain_d <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_FIN && out_free)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid)
                        r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_step <= '0;
                    if (r_bits == '0 || lk.hit)
                        r_state <= S_MUL;
                    else
                        r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= '0;
                    if (div_done)
                        r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd3)
                        r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_last      <= r_err;
                        if (r_rec) begin
                            for (int k = 0; k < HISTORY_DEPTH - 1; k++)
                                r_hist[k] <= r_hist[k+1];
                            r_hist[HISTORY_DEPTH-1] <= r_err;
                            r_hsum <= r_hsum - HSUM_W'(r_hist[0]) + HSUM_W'(r_err);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_bits <= i_sensor_bits;
            r_rec  <= i_record_history;
        end
        if (r_state == S_LOOK) begin
            r_neg <= num[NUM_W-1];
            r_acc <= '0;
            if (r_bits == '0)
                r_err <= r_last;
            else if (lk.hit)
                r_err <= sat_err(32'(lk.half) <<< (FRAC_BITS - 1));
        end
        if (r_state == S_DIV && div_done)
            r_err <= sat_err(32'(quo_s));
        if (r_state == S_MUL) begin
            r_prod <= mul_a * mul_b;
            if (r_step != 2'd0)
                r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_state == S_FIN && out_free) begin
            r_out_err <= r_err;
            r_out_ctl <= ctl_sat;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_position_error = r_out_err;
    assign o_control_out    = r_out_ctl;

endmodule

[dv/line_position_pid_tb.sv]
// line_position_pid_tb: self-checking testbench for the line position pid block
// drives sensor patterns and gain writes, predicts error and correction per transfer
// depends on lpp_pkg and line_position_pid
`timescale 1ns / 100ps

module line_position_pid_tb;
    import lpp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int CTL_LO = -(1 << (CTL_W - 1));
    localparam int CTL_HI = (1 << (CTL_W - 1)) - 1;
    localparam int IDLE_PCT = 18;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 106;

    localparam int SENSOR_WEIGHT [8] = '{-6, -4, -2, -1, 1, 2, 4, 6};
    localparam logic [7:0] TABLE_PATTERNS [24] = '{
        8'h18, 8'h3C, 8'h08, 8'h20, 8'h02, 8'h40, 8'h01, 8'h80,
        8'h0C, 8'h30, 8'h06, 8'h60, 8'h03, 8'hC0,
        8'h1C, 8'h38, 8'h0E, 8'h70, 8'h07, 8'hE0,
        8'h1E, 8'h78, 8'h0F, 8'hF0
    };
    // {record, pattern}
    localparam logic [8:0] DIRECTED_ITEMS [22] = '{
        {1'b1, 8'h00}, {1'b1, 8'h80}, {1'b1, 8'h01}, {1'b1, 8'h0F},
        {1'b0, 8'hF0}, {1'b1, 8'h18}, {1'b1, 8'h3C}, {1'b1, 8'h1C},
        {1'b1, 8'h38}, {1'b1, 8'h07}, {1'b1, 8'hE0}, {1'b1, 8'h0E},
        {1'b0, 8'h70}, {1'b1, 8'hFF}, {1'b1, 8'h81}, {1'b1, 8'hAA},
        {1'b1, 8'h55}, {1'b1, 8'h11}, {1'b1, 8'h00}, {1'b0, 8'h41},
        {1'b1, 8'h13}, {1'b1, 8'hC1}
    };

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [CTL_W-1:0] ctl;
    } t_pid_result;

    class correction_tracker;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        t_err prev_err;
        t_err window [HISTORY_DEPTH];
        int window_sum;
        int failures;
        t_pid_result expected[$];

        function new();
            gain_p = '0;
            gain_i = '0;
            gain_d = '0;
            prev_err = '0;
            foreach (window[i]) window[i] = '0;
            window_sum = 0;
            failures = 0;
        endfunction

        function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
            case (idx)
                REG_GAIN_PROP:  gain_p = data;
                REG_GAIN_INTEG: gain_i = data;
                REG_GAIN_DERIV: gain_d = data;
                default: ;
            endcase
        endfunction

        function t_err pattern_error(logic [7:0] bits);
            int half;
            bit hit;
            int wsum;
            int cnt;
            int e;
            hit = 1'b1;
            half = 0;
            wsum = 0;
            cnt = 0;
            case (bits)
                8'h18, 8'h3C:        half = 0;
                8'h08, 8'h0C, 8'h1E: half = 15;
                8'h20, 8'h30, 8'h78: half = -15;
                8'h02, 8'h06, 8'h0F: half = 25;
                8'h40, 8'h60, 8'hF0: half = -25;
                8'h01, 8'h03:        half = 60;
                8'h80, 8'hC0:        half = -60;
                8'h1C:               half = 8;
                8'h38:               half = -8;
                8'h0E:               half = 20;
                8'h70:               half = -20;
                8'h07:               half = 32;
                8'hE0:               half = -32;
                default:             hit = 1'b0;
            endcase
            // no line seen: keep the last error
            if (bits == 8'h00) return prev_err;
            if (hit) return t_err'(half * (1 << (FRAC_BITS - 1)));
            for (int i = 0; i < 8; i++) begin
                if (bits[7-i]) begin
                    wsum += SENSOR_WEIGHT[i];
                    cnt++;
                end
            end
            // signed int division truncates toward zero
            e = (5 * wsum * (1 << FRAC_BITS)) / cnt;
            if (e < ERR_MIN) e = ERR_MIN;
            if (e > ERR_MAX) e = ERR_MAX;
            return t_err'(e);
        endfunction

        function void note_pattern(logic [7:0] bits, logic rec);
            t_err e;
            longint acc;
            t_pid_result r;
            e = pattern_error(bits);
            acc = longint'(gain_p) * longint'(e)
                + longint'(gain_i) * longint'(window_sum)
                + longint'(gain_d) * longint'(int'(e) - int'(prev_err));
            acc = acc >>> 8;
            if (acc < longint'(CTL_LO)) acc = longint'(CTL_LO);
            if (acc > longint'(CTL_HI)) acc = longint'(CTL_HI);
            prev_err = e;
            if (rec) begin
                window_sum -= int'(window[0]);
                for (int i = 0; i < HISTORY_DEPTH - 1; i++) window[i] = window[i+1];
                window[HISTORY_DEPTH-1] = e;
                window_sum += int'(e);
            end
            r.err = e;
            r.ctl = acc[CTL_W-1:0];
            expected.push_back(r);
        endfunction

        function void check_correction(logic signed [ERR_W-1:0] err,
                                       logic signed [CTL_W-1:0] ctl);
            t_pid_result r;
            if (expected.size() == 0) begin
                $error("result with nothing pending: position_error %0d control_out %0d",
                       err, ctl);
                failures++;
                return;
            end
            r = expected.pop_front();
            if (err !== r.err) begin
                $error("position_error: expected %0d, actual %0d", r.err, err);
                failures++;
            end
            if (ctl !== r.ctl) begin
                $error("control_out: expected %0d, actual %0d", r.ctl, ctl);
                failures++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [SENS_W-1:0]       i_sensor_bits;
    logic                    i_record_history;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [ERR_W-1:0] o_position_error;
    logic signed [CTL_W-1:0] o_control_out;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [GAIN_W-1:0]       i_cfg_data;

    correction_tracker tracker;
    bit quiet;
    bit hold_request;

    line_position_pid dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sensor_bits    (i_sensor_bits),
        .i_record_history (i_record_history),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_position_error (o_position_error),
        .o_control_out    (o_control_out),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side: check each transfer, then pick ready for the next edge
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                tracker.check_correction(o_position_error, o_control_out);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("line_position_pid_tb failed");
        $finish;
    end

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.set_gain(idx, data);
        @(posedge i_clk);
    endtask

    task automatic write_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                               input logic [GAIN_W-1:0] d);
        write_gain(REG_GAIN_PROP, p);
        write_gain(REG_GAIN_INTEG, i);
        write_gain(REG_GAIN_DERIV, d);
    endtask

    task automatic send_pattern(input logic [7:0] bits, input logic rec);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_sensor_bits    <= bits;
        i_record_history <= rec;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_pattern(bits, rec);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.expected.size() != 0) @(posedge i_clk);
    endtask

    // mostly arbitrary patterns, with table patterns and the lost line mixed in
    task automatic send_random(input int n, input bit with_hold);
        int roll;
        logic [7:0] bits;
        for (int k = 0; k < n; k++) begin
            if (with_hold && (k == 10 || k == 60)) hold_request = 1'b1;
            roll = $urandom_range(99);
            if (roll < 30)
                bits = TABLE_PATTERNS[$urandom_range(23)];
            else if (roll < 42)
                bits = 8'h00;
            else
                bits = 8'($urandom_range(255));
            send_pattern(bits, $urandom_range(99) < 70);
        end
        drain_results();
    endtask

    initial begin
        tracker = new();
        quiet = 1'b0;
        hold_request = 1'b0;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_sensor_bits    <= '0;
        i_record_history <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= REG_GAIN_PROP;
        i_cfg_data       <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: table entries, lost line, truncation and the spare index
        write_gain(CFG_IDX_SPARE, 16'h1234);
        write_gains(16'h0100, 16'h0020, 16'hFF80);
        foreach (DIRECTED_ITEMS[k])
            send_pattern(DIRECTED_ITEMS[k][7:0], DIRECTED_ITEMS[k][8]);
        drain_results();

        write_gains(GAIN_W'($urandom_range(16'hFFFF)), GAIN_W'($urandom_range(16'hFFFF)),
                    GAIN_W'($urandom_range(16'hFFFF)));
        send_random(RANDOM_ITEMS, 1'b0);

        // long stretch with no idling on either side
        quiet = 1'b1;
        write_gains(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_random(RANDOM_ITEMS, 1'b0);
        quiet = 1'b0;

        write_gains(16'h8000, 16'h8000, 16'h8000);
        send_random(RANDOM_ITEMS, 1'b1);

        write_gain(CFG_IDX_SPARE, GAIN_W'($urandom_range(16'hFFFF)));
        write_gains(GAIN_W'($urandom_range(16'hFFFF)), GAIN_W'($urandom_range(16'hFFFF)),
                    GAIN_W'($urandom_range(16'hFFFF)));
        send_random(RANDOM_ITEMS, 1'b0);

        write_gains(16'h0000, 16'hFFFF, GAIN_W'($urandom_range(16'hFFFF)));
        send_random(RANDOM_ITEMS, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.expected.size() == 0)
            $display("line_position_pid_tb passed");
        else
            $display("line_position_pid_tb failed");
        $finish;
    end

endmodule
